// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the command file tokenizer.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: the consequent must hold in the same cycle.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cft_pkg.sv -----
// Package for the command file tokenizer: token codes, result types,
// buffer limits and the keyword table. Depends on nothing.
package cft_pkg;

	// Buffer limits of the tokenizer.
	localparam int STRING_BUFFER = 256;
	localparam int WORD_BUFFER   = 30;
	localparam int KEEP_CHARS    = 7;
	localparam int KW_COUNT      = 7;

	localparam int SCOUNT_W = $clog2(STRING_BUFFER);
	localparam int WLEN_W   = $clog2(WORD_BUFFER);
	localparam int KIDX_W   = $clog2(KEEP_CHARS);

	// Result queue geometry.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;
	localparam logic [PTR_W-1:0] PTR_ONE = 1;
	localparam logic [PTR_W-1:0] PTR_TWO = 2;
	localparam logic [CNT_W-1:0] CNT_ONE = 1;
	localparam logic [CNT_W-1:0] CNT_TWO = 2;

	// Token kinds.
	localparam logic [3:0] TK_CMD    = 4'd0;
	localparam logic [3:0] TK_STREND = 4'd1;
	localparam logic [3:0] TK_NUM    = 4'd2;
	localparam logic [3:0] TK_ID     = 4'd3;
	localparam logic [3:0] TK_EOF    = 4'd4;
	localparam logic [3:0] TK_SLASH  = 4'd5;
	localparam logic [3:0] TK_DOT    = 4'd6;
	localparam logic [3:0] TK_UNK    = 4'd7;
	localparam logic [3:0] TK_BODY   = 4'd8;

	// Characters with a special meaning.
	localparam logic [7:0] CH_EOF    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef logic [KEEP_CHARS-1:0][7:0] word_t;

	// One result item.
	typedef struct packed {
		logic [3:0] kind;
		logic [2:0] cmd;
		logic [7:0] chv;
		logic [7:0] len;
	} token_t;

	// Results of one step of the lexer, in delivery order.
	typedef struct packed {
		logic [1:0] n;
		token_t     first;
		token_t     second;
	} emit_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] id;
	} kw_result_t;

	// Keyword text, first character in the most significant byte.
	function automatic logic [KEEP_CHARS-1:0][7:0] kw_text(input int k);
		case (k)
			0:       kw_text = "SERVER ";
			1:       kw_text = "QUIT   ";
			2:       kw_text = "SEND   ";
			3:       kw_text = "RECEIVE";
			4:       kw_text = "GET    ";
			5:       kw_text = "INPUT  ";
			default: kw_text = "OUTPUT ";
		endcase
	endfunction

	function automatic int kw_len(input int k);
		case (k)
			0:       kw_len = 6;
			1:       kw_len = 4;
			2:       kw_len = 4;
			3:       kw_len = 7;
			4:       kw_len = 3;
			5:       kw_len = 5;
			default: kw_len = 6;
		endcase
	endfunction

	// Upper-case fold of a lower-case letter.
	function automatic logic [7:0] fold(input logic [7:0] c);
		fold = (c >= "a" && c <= "z") ? 8'(c - 8'd32) : c;
	endfunction

	// Compare the stored word against every keyword in parallel.
	function automatic kw_result_t kw_match(input logic [WLEN_W-1:0] wlen, input word_t chars);
		kw_result_t r;
		logic       same;
		logic [KEEP_CHARS-1:0][7:0] txt;
		r = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			txt = kw_text(k);
			same = (int'(wlen) == kw_len(k));
			for (int i = 0; i < KEEP_CHARS; i++) begin
				if (i < kw_len(k) && chars[i] != txt[KEEP_CHARS-1-i])
					same = 1'b0;
			end
			if (same && !r.hit) begin
				r.hit = 1'b1;
				r.id  = 3'(k);
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/cft_lexer.sv -----
// Lexer state machine of the command file tokenizer: consumes one character
// per step and produces up to two tokens. Depends on cft_pkg.
module cft_lexer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     ch,
	output cft_pkg::emit_t emit
);

	typedef enum logic [2:0] {
		M_TOP,
		M_SLASH,
		M_COMMENT,
		M_STAR,
		M_STRING,
		M_ESCAPE,
		M_WORD
	} mode_t;

	mode_t                        mode_q, mode_d;
	logic [cft_pkg::WLEN_W-1:0]   wlen_q, wlen_d;
	logic [cft_pkg::SCOUNT_W-1:0] scount_q, scount_d;
	cft_pkg::word_t               word_q;

	logic                         wc_we;
	logic [cft_pkg::KIDX_W-1:0]   wc_idx;
	logic [7:0]                   wc_data;
	logic [7:0]                   u;
	logic                         do_top;
	logic                         str_go;
	logic [7:0]                   str_c;
	logic                         pre_v, post_v;
	cft_pkg::token_t              pre, post;
	cft_pkg::kw_result_t          kw;

	localparam logic [cft_pkg::WLEN_W-1:0]   WLEN_ONE   = 1;
	localparam logic [cft_pkg::SCOUNT_W-1:0] SCOUNT_ONE = 1;

	// Next state and emitted tokens for the current character.
	always_comb begin
		mode_d   = mode_q;
		wlen_d   = wlen_q;
		scount_d = scount_q;
		wc_we    = 1'b0;
		wc_idx   = '0;
		wc_data  = '0;
		do_top   = 1'b0;
		str_go   = 1'b0;
		str_c    = '0;
		pre_v    = 1'b0;
		pre      = '0;
		post_v   = 1'b0;
		post     = '0;
		u        = cft_pkg::fold(ch);
		kw       = cft_pkg::kw_match(wlen_q, word_q);

		case (mode_q)
			M_SLASH: begin
				if (ch == cft_pkg::CH_STAR) begin
					mode_d = M_COMMENT;
				end else begin
					pre_v    = 1'b1;
					pre.kind = cft_pkg::TK_SLASH;
					do_top   = 1'b1;
				end
			end
			M_COMMENT, M_STAR: begin
				if (ch == cft_pkg::CH_EOF) begin
					post_v    = 1'b1;
					post.kind = cft_pkg::TK_EOF;
					mode_d    = M_TOP;
				end else if (ch == cft_pkg::CH_STAR) begin
					mode_d = M_STAR;
				end else if (ch == cft_pkg::CH_SLASH && mode_q == M_STAR) begin
					mode_d = M_TOP;
				end else begin
					mode_d = M_COMMENT;
				end
			end
			M_STRING: begin
				if (ch == cft_pkg::CH_BSLASH) begin
					mode_d = M_ESCAPE;
				end else begin
					str_go = 1'b1;
					str_c  = (ch == cft_pkg::CH_QUOTE) ? cft_pkg::CH_EOF : ch;
				end
			end
			M_ESCAPE: begin
				str_go = 1'b1;
				case (ch)
					"n":     str_c = 8'd10;
					"b":     str_c = 8'd8;
					"t":     str_c = 8'd9;
					default: str_c = ch;
				endcase
			end
			M_WORD: begin
				if (((u >= "A" && u <= "Z") || (u >= "0" && u <= "9"))
						&& int'(wlen_q) < cft_pkg::WORD_BUFFER - 1) begin
					if (int'(wlen_q) < cft_pkg::KEEP_CHARS) begin
						wc_we   = 1'b1;
						wc_idx  = wlen_q[cft_pkg::KIDX_W-1:0];
						wc_data = u;
					end
					wlen_d = wlen_q + WLEN_ONE;
				end else begin
					pre_v = 1'b1;
					if (kw.hit) begin
						pre.kind = cft_pkg::TK_CMD;
						pre.cmd  = kw.id;
					end else begin
						pre.kind = cft_pkg::TK_ID;
					end
					do_top = 1'b1;
				end
			end
			default: begin
				do_top = 1'b1;
			end
		endcase

		// A character inside a string: body token while the string buffer has room, or closing length token.
		if (str_go) begin
			mode_d = M_STRING;
			if (str_c == cft_pkg::CH_EOF) begin
				post_v    = 1'b1;
				post.kind = cft_pkg::TK_STREND;
				post.len  = 8'(scount_q);
				mode_d    = M_TOP;
			end else if (int'(scount_q) < cft_pkg::STRING_BUFFER - 1) begin
				post_v    = 1'b1;
				post.kind = cft_pkg::TK_BODY;
				post.chv  = str_c;
				scount_d  = scount_q + SCOUNT_ONE;
			end
		end

		// The character starts a new token at the top level.
		if (do_top) begin
			mode_d = M_TOP;
			if (ch == cft_pkg::CH_EOF) begin
				post_v    = 1'b1;
				post.kind = cft_pkg::TK_EOF;
			end else if (ch <= cft_pkg::CH_SPACE || ch[7]) begin
				post_v = 1'b0;
			end else if (ch == cft_pkg::CH_SLASH) begin
				mode_d = M_SLASH;
			end else if (ch == cft_pkg::CH_QUOTE) begin
				mode_d   = M_STRING;
				scount_d = '0;
			end else if (ch >= "0" && ch <= "9") begin
				post_v    = 1'b1;
				post.kind = cft_pkg::TK_NUM;
			end else if (u >= "A" && u <= "Z") begin
				wc_we   = 1'b1;
				wc_idx  = '0;
				wc_data = u;
				wlen_d  = WLEN_ONE;
				mode_d  = M_WORD;
			end else if (ch == cft_pkg::CH_DOT) begin
				post_v    = 1'b1;
				post.kind = cft_pkg::TK_DOT;
			end else begin
				post_v    = 1'b1;
				post.kind = cft_pkg::TK_UNK;
			end
		end

		emit.n      = {1'b0, pre_v} + {1'b0, post_v};
		emit.first  = pre_v ? pre : post;
		emit.second = post;
	end

	// Lexer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_TOP;
			wlen_q   <= '0;
			scount_q <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			wlen_q   <= wlen_d;
			scount_q <= scount_d;
		end
	end

	// Stored leading characters of the current word.
	always_ff @(posedge clk) begin
		if (step && wc_we)
			word_q[wc_idx] <= wc_data;
	end

endmodule

// ----- rtl/cft_result_fifo.sv -----
// Result queue of the command file tokenizer: takes up to two tokens per
// cycle and hands out one per transfer. Depends on cft_pkg.
module cft_result_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cft_pkg::emit_t  emit,
	input  logic            pop,
	output logic            room,
	output logic            valid,
	output cft_pkg::token_t head
);

	cft_pkg::token_t             mem [cft_pkg::FIFO_DEPTH];
	logic [cft_pkg::PTR_W-1:0]   wr_q, rd_q;
	logic [cft_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [cft_pkg::PTR_W-1:0]   wr_next;
	logic [1:0]                  n_in;

	assign n_in  = push ? emit.n : 2'd0;
	assign room  = int'(cnt_q) <= cft_pkg::FIFO_DEPTH - 2;
	assign valid = cnt_q != '0;
	assign head  = mem[rd_q];

	// Fill level after this cycle's writes and read.
	always_comb begin
		cnt_d   = cnt_q;
		wr_next = wr_q;
		if (n_in == 2'd2) begin
			cnt_d   = cnt_d + cft_pkg::CNT_TWO;
			wr_next = wr_q + cft_pkg::PTR_TWO;
		end else if (n_in == 2'd1) begin
			cnt_d   = cnt_d + cft_pkg::CNT_ONE;
			wr_next = wr_q + cft_pkg::PTR_ONE;
		end
		if (pop)
			cnt_d = cnt_d - cft_pkg::CNT_ONE;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_next;
			cnt_q <= cnt_d;
			if (pop)
				rd_q <= rd_q + cft_pkg::PTR_ONE;
		end
	end

	// Token storage.
	always_ff @(posedge clk) begin
		if (n_in != 2'd0)
			mem[wr_q] <= emit.first;
		if (n_in == 2'd2)
			mem[wr_q + cft_pkg::PTR_ONE] <= emit.second;
	end

endmodule

// ----- rtl/command_file_tokenizer.sv -----
// Top level of the command file tokenizer: input register, lexer and result
// queue. Depends on cft_pkg, cft_lexer, cft_result_fifo and assert_macros.svh.

// The tokenizer takes one byte of command text per cycle while in_stall is
// low and reports tokens: commands, identifiers, digits, string body
// characters and string lengths, slash, dot, unknown bytes and end of input.
// A byte enters an input register and is lexed there once the result queue
// has room; its tokens are registered into a four-entry result queue, from
// which the first token of the byte is offered. A byte that closes a word or
// follows a lone slash can yield two tokens; the output drains one token per
// cycle while out_stall is low, so such bytes stretch the input rate to what
// the output port delivers. Input stalls while the byte held in the input
// register waits for two free queue entries.
// There is no clearing pass after reset.
`include "assert_macros.svh"

module command_file_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] token_kind,
	output logic [2:0] command_id,
	output logic [7:0] char_value,
	output logic [7:0] string_length
);

	logic            valid_s1;
	logic [7:0]      char_s1;
	logic            room;
	logic            fire;
	logic            load;
	logic            pop;
	cft_pkg::emit_t  emit;
	cft_pkg::token_t head;

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign load     = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			char_s1 <= in_char;
	end

	cft_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.ch     (char_s1),
		.emit   (emit)
	);

	cft_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.emit   (emit),
		.pop    (pop),
		.room   (room),
		.valid  (out_valid),
		.head   (head)
	);

	assign token_kind    = head.kind;
	assign command_id    = head.cmd;
	assign char_value    = head.chv;
	assign string_length = head.len;

	// Checks on the lexer and the queue.
	`ASSERT_NEXT(a_two_tokens_out, fire && emit.n == 2'd2, out_valid, "tokens lost in queue")
	`ASSERT_NOW(a_len_only_strend, out_valid && token_kind != cft_pkg::TK_STREND, string_length == 8'd0, "stray length")
	`ASSERT_NOW(a_cmd_only_cmd, out_valid && token_kind != cft_pkg::TK_CMD, command_id == 3'd0, "stray command id")
	`ASSERT_NOW(a_chv_only_body, out_valid && token_kind != cft_pkg::TK_BODY, char_value == 8'd0, "stray character")
	`ASSERT_NOW(a_stall_needs_item, in_stall, valid_s1, "stall without held byte")

endmodule
